[rtl/pkb_pkg.sv]
// shared types and constants for the packbits encoder
package pkb_pkg;

  localparam int MaxLiteralDefault = 32;
  localparam int CmdFifoDepth      = 4;

  localparam logic [7:0] RunLimit = 8'd128;
  localparam logic [8:0] RunBase  = 9'd257;
  localparam logic [7:0] EndMark  = 8'd128;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // work orders from the classifier to the emitter
  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_FLUSH,
    CMD_BYTE,
    CMD_RUN
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] data;
    logic [7:0] cnt;
    logic       flush;
    logic       last;
  } cmd_t;

endpackage

[rtl/packbits_encoder_top.sv]
// packbits run-length encoder, top level
//
// Encodes a byte stream in packbits form. Each input transaction carries one
// byte and an end-of-stream flag; each output transaction carries one encoded
// byte, with out_last marking the final byte caused by a given input byte.
// Two or more equal bytes become a run packet (header 257 - count, then the
// byte), cut at 128; other bytes gather into literal packets (header
// length - 1, then the bytes) of at most MAX_LITERAL bytes. The byte flagged
// end_of_stream flushes everything, is followed by the end marker 128, and
// returns the encoder to its reset state for the next stream.
// Timing: a classifier takes one input byte per cycle while the four-entry
// command queue has room; an end-of-stream byte then keeps it busy while it
// releases the held byte, flushes the literal buffer and queues the end
// marker. An emitter behind the queue takes the commands in order: a run
// command puts out its header and then its byte from state B_RUNB; a literal
// byte is written into the literal buffer memory with no output, and a
// literal packet then goes out header first, one byte per cycle while the
// output register takes bytes, with the registered read of the buffer
// running one byte ahead. A flush command without a literal byte is popped
// on its own ahead of its packet. Every output byte passes an output register
// that takes a new byte when it is empty or drained by out_ready_i. Over a
// long stream the emitter sets the rate, as each literal byte passes it
// twice, as buffer write and output, so input accept follows output ready.
module packbits_encoder_top
  import pkb_pkg::*;
#(
  parameter int MAX_LITERAL = MaxLiteralDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // classifier to queue
  logic push;
  cmd_t push_cmd;
  logic fifo_full;

  // queue to emitter
  logic cmd_valid;
  cmd_t cmd;
  logic pop;

  // front: decides runs and literals for each input transaction
  pkb_front #(
    .MAX_LITERAL(MAX_LITERAL)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (fifo_full)
  );

  // commands in order, so literal writes always precede their flush
  pkb_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .valid_o    (cmd_valid),
    .pop_cmd_o  (cmd)
  );

  // back: literal buffer and byte-wise output
  pkb_back #(
    .MAX_LITERAL(MAX_LITERAL)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[rtl/pkb_cmd_fifo.sv]
// short command queue between the classifier and the emitter
module pkb_cmd_fifo
  import pkb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_cmd_o
);

  localparam int PtrW = $clog2(CmdFifoDepth);

  cmd_t            slot_q [CmdFifoDepth];
  logic [PtrW:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW:0]   rd_ptr_q, rd_ptr_d;

  assign valid_o   = (wr_ptr_q != rd_ptr_q);
  assign full_o    = (wr_ptr_q[PtrW] != rd_ptr_q[PtrW]) &&
                     (wr_ptr_q[PtrW-1:0] == rd_ptr_q[PtrW-1:0]);
  assign pop_cmd_o = slot_q[rd_ptr_q[PtrW-1:0]];

  assign wr_ptr_d = wr_ptr_q + (PtrW+1)'(1);
  assign rd_ptr_d = rd_ptr_q + (PtrW+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= wr_ptr_d;
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= rd_ptr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      slot_q[wr_ptr_q[PtrW-1:0]] <= push_cmd_i;
    end
  end

endmodule

[rtl/pkb_front.sv]
// classifier: tracks the held byte, run count and literal count, issues commands
module pkb_front
  import pkb_pkg::*;
#(
  parameter int MAX_LITERAL = MaxLiteralDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     push_o,
  output cmd_t     push_cmd_o,
  input  logic     full_i
);

  localparam int LW = $clog2(MAX_LITERAL + 1);

  typedef enum logic [1:0] {
    F_IDLE,
    F_TAIL_REL,
    F_TAIL_FLUSH,
    F_END
  } front_state_e;

  front_state_e  state_q, state_d;
  logic [7:0]    held_q, held_d;
  logic          held_valid_q, held_valid_d;
  logic [7:0]    rc_q, rc_d;
  logic [LW-1:0] lit_q, lit_d;

  logic          match;
  logic          rel_is_run;
  logic [LW-1:0] lit_inc;
  logic          lit_full;
  cmd_t          rel_cmd;
  logic [LW-1:0] rel_lit;
  logic [7:0]    rc_inc;

  always_comb begin
    rc_inc     = rc_q + 8'd1;
    match      = held_valid_q && (in_item_i.data_byte == held_q);
    rel_is_run = (rc_q >= 8'd2);
    lit_inc    = lit_q + LW'(1);
    lit_full   = (lit_inc == LW'(MAX_LITERAL));

    // what releasing the held byte turns into
    rel_cmd.op    = rel_is_run ? CMD_RUN : CMD_ADD;
    rel_cmd.data  = held_q;
    rel_cmd.cnt   = rc_q;
    rel_cmd.flush = !rel_is_run && lit_full;
    rel_cmd.last  = 1'b0;
    rel_lit       = rel_is_run ? lit_q : (lit_full ? '0 : lit_inc);
  end

  always_comb begin
    state_d      = state_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    rc_d         = rc_q;
    lit_d        = lit_q;
    push_o       = 1'b0;
    push_cmd_o   = rel_cmd;
    in_ready_o   = (state_q == F_IDLE) && !full_i;

    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (match) begin
            rc_d = rc_inc;
            if (rc_q == 8'd1 && lit_q != '0) begin
              // a pair begins: pending literal goes out first
              push_o           = 1'b1;
              push_cmd_o.op    = CMD_FLUSH;
              push_cmd_o.flush = 1'b0;
              push_cmd_o.last  = !in_item_i.end_of_stream;
              lit_d            = '0;
            end else if (rc_inc == RunLimit) begin
              push_o           = 1'b1;
              push_cmd_o.op    = CMD_RUN;
              push_cmd_o.cnt   = RunLimit;
              push_cmd_o.flush = 1'b0;
              push_cmd_o.last  = !in_item_i.end_of_stream;
              held_valid_d     = 1'b0;
              rc_d             = '0;
            end
          end else begin
            if (held_valid_q) begin
              push_o          = 1'b1;
              push_cmd_o.last = !in_item_i.end_of_stream;
              lit_d           = rel_lit;
            end
            held_d       = in_item_i.data_byte;
            held_valid_d = 1'b1;
            rc_d         = 8'd1;
          end
          if (in_item_i.end_of_stream) begin
            state_d = F_TAIL_REL;
          end
        end
      end
      F_TAIL_REL: begin
        if (!held_valid_q) begin
          state_d = F_TAIL_FLUSH;
        end else if (!full_i) begin
          push_o       = 1'b1;
          lit_d        = rel_lit;
          held_valid_d = 1'b0;
          rc_d         = '0;
          state_d      = F_TAIL_FLUSH;
        end
      end
      F_TAIL_FLUSH: begin
        if (lit_q == '0) begin
          state_d = F_END;
        end else if (!full_i) begin
          push_o           = 1'b1;
          push_cmd_o.op    = CMD_FLUSH;
          push_cmd_o.flush = 1'b0;
          lit_d            = '0;
          state_d          = F_END;
        end
      end
      F_END: begin
        if (!full_i) begin
          push_o           = 1'b1;
          push_cmd_o.op    = CMD_BYTE;
          push_cmd_o.data  = EndMark;
          push_cmd_o.flush = 1'b0;
          push_cmd_o.last  = 1'b1;
          held_d           = '0;
          state_d          = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      rc_q         <= '0;
      lit_q        <= '0;
    end else begin
      state_q      <= state_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      rc_q         <= rc_d;
      lit_q        <= lit_d;
    end
  end

endmodule

[rtl/pkb_back.sv]
// emitter: literal buffer memory and output register, one byte per cycle while the output register can take it
module pkb_back
  import pkb_pkg::*;
#(
  parameter int MAX_LITERAL = MaxLiteralDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int LW = $clog2(MAX_LITERAL + 1);
  localparam int AW = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FLUSH,
    B_RUNB,
    B_LIT
  } back_state_e;

  back_state_e   state_q, state_d;
  logic [LW-1:0] wcnt_q, wcnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [7:0]    data_q, data_d;
  logic          last_q, last_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_item_q;

  logic [7:0]    lit_mem_q [MAX_LITERAL];
  logic [7:0]    rdata_q;

  logic          slot_free;
  logic          load;
  out_item_t     load_item;
  logic          mem_we;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          lit_end;
  logic [7:0]    run_hdr;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign lit_end     = (LW'(idx_q) == (wcnt_q - LW'(1)));
  assign run_hdr     = 8'(RunBase - {1'b0, cmd_i.cnt});
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    state_d   = state_q;
    wcnt_d    = wcnt_q;
    idx_d     = idx_q;
    data_d    = data_q;
    last_d    = last_q;
    pop_o     = 1'b0;
    load      = 1'b0;
    load_item = '0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;

    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            CMD_ADD: begin
              pop_o  = 1'b1;
              mem_we = 1'b1;
              wcnt_d = wcnt_q + LW'(1);
              if (cmd_i.flush) begin
                last_d  = cmd_i.last;
                state_d = B_FLUSH;
              end
            end
            CMD_FLUSH: begin
              pop_o   = 1'b1;
              last_d  = cmd_i.last;
              state_d = B_FLUSH;
            end
            CMD_BYTE: begin
              if (slot_free) begin
                pop_o              = 1'b1;
                load               = 1'b1;
                load_item.out_byte = cmd_i.data;
                load_item.out_last = cmd_i.last;
              end
            end
            CMD_RUN: begin
              if (slot_free) begin
                pop_o              = 1'b1;
                load               = 1'b1;
                load_item.out_byte = run_hdr;
                load_item.out_last = 1'b0;
                data_d             = cmd_i.data;
                last_d             = cmd_i.last;
                state_d            = B_RUNB;
              end
            end
          endcase
        end
      end
      B_FLUSH: begin
        if (slot_free) begin
          // literal header, first buffered byte fetched alongside
          load               = 1'b1;
          load_item.out_byte = 8'(wcnt_q) - 8'd1;
          load_item.out_last = 1'b0;
          rd_en              = 1'b1;
          idx_d              = '0;
          state_d            = B_LIT;
        end
      end
      B_RUNB: begin
        if (slot_free) begin
          load               = 1'b1;
          load_item.out_byte = data_q;
          load_item.out_last = last_q;
          state_d            = B_IDLE;
        end
      end
      B_LIT: begin
        if (slot_free) begin
          load               = 1'b1;
          load_item.out_byte = rdata_q;
          load_item.out_last = lit_end && last_q;
          if (lit_end) begin
            wcnt_d  = '0;
            state_d = B_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_q + AW'(1);
            idx_d   = idx_q + AW'(1);
          end
        end
      end
      default: state_d = B_IDLE;
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      wcnt_q      <= '0;
      idx_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wcnt_q      <= wcnt_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (load) begin
      out_item_q <= load_item;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lit_mem_q[wcnt_q[AW-1:0]] <= cmd_i.data;
    end
    if (rd_en) begin
      rdata_q <= lit_mem_q[rd_addr];
    end
  end

endmodule
